[hdl/audio_jitter_buffer_playout_unit_defines.svh]
// Assertion macros shared by the jitter buffer checker.
`ifndef AUDIO_JITTER_BUFFER_PLAYOUT_UNIT_DEFINES_SVH
`define AUDIO_JITTER_BUFFER_PLAYOUT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define AJB_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ajb checker: same-cycle property violated");

// Next-cycle implication, disabled while in reset.
`define AJB_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ajb checker: next-cycle property violated");

`endif

[hdl/ajb_pkg.sv]
// Shared types and constants for the audio jitter buffer playout unit.
package ajb_pkg;

  localparam int ACTION_W           = 2;
  localparam int FRAME_W            = 32;
  localparam int SLOT_W             = 6;
  localparam int STATUS_W           = 3;
  localparam int THR_W              = 6;
  localparam int DEFAULT_RING_DEPTH = 64;
  localparam logic [THR_W-1:0] THR_RESET = 6'd24;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_PULL = 2'd1,
    ACT_WIPE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLAYING = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FILLING = 3'd2,
    ST_STARTED = 3'd3,
    ST_GAP     = 3'd4,
    ST_OTHER   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_RDA,
    S_RDB,
    S_CMP,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] play_slot;
    logic              silence;
    status_t           status;
    logic              pushed_ok;
  } result_t;

endpackage

[hdl/ajb_if.sv]
// Handshake channels of the jitter buffer: request, result and config words.
interface ajb_req_if;
  logic                         valid;
  logic                         ready;
  logic [ajb_pkg::ACTION_W-1:0] action;
  logic [ajb_pkg::FRAME_W-1:0]  frame_number;

  modport source (output valid, action, frame_number, input ready);
  modport sink   (input valid, action, frame_number, output ready);
endinterface

interface ajb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ajb_pkg::SLOT_W-1:0]   play_slot;
  logic                         silence;
  logic [ajb_pkg::STATUS_W-1:0] status;
  logic                         pushed_ok;

  modport source (output valid, play_slot, silence, status, pushed_ok, input ready);
  modport sink   (input valid, play_slot, silence, status, pushed_ok, output ready);
endinterface

interface ajb_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ajb_pkg::THR_W-1:0] start_threshold;

  modport source (output valid, start_threshold, input ready);
  modport sink   (input valid, start_threshold, output ready);
endinterface

[hdl/audio_jitter_buffer_playout_unit.sv]
// Audio jitter buffer playout unit: top level with config and output registers.
//
// One request word carries an action: push a received frame number into the
// ring, pull the next slot to play, or wipe the queue. Every request yields
// exactly one result word (play_slot, silence, status, pushed_ok). Requests are
// handled one at a time; a new request is taken while the previous result
// still waits in the output register. A pull while playing that must check
// sequence continuity reads the last played and the head frame numbers one
// after another through the single read port of the ring store. A pull that
// restarts playout scans every queued frame number through that read port,
// one per cycle. The ring store is not cleared after reset; only data of
// slots once written is used. The start_threshold register (reset 24) is
// written through the cfg channel, which is always ready, and should only be
// written while the unit is idle.
module audio_jitter_buffer_playout_unit #(
  parameter int RING_DEPTH = ajb_pkg::DEFAULT_RING_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  ajb_req_if.sink   req,
  ajb_rsp_if.source rsp,
  ajb_cfg_if.sink   cfg
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [ajb_pkg::THR_W-1:0]   start_threshold;
  logic                        res_valid, res_ready;
  ajb_pkg::result_t            res, out_res;
  logic                        out_valid;
  logic                        mem_we;
  logic [PTR_W-1:0]            mem_waddr, mem_raddr;
  logic [ajb_pkg::FRAME_W-1:0] mem_wdata, mem_rdata;

  // Threshold register; the config word is always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold <= ajb_pkg::THR_RESET;
    end else if (cfg.valid) begin
      start_threshold <= cfg.start_threshold;
    end
  end

  ajb_seq #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start_threshold (start_threshold),
    .req             (req),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  ajb_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W),
    .DATA_W (ajb_pkg::FRAME_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: decouples the sequencer from a stalled consumer.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.play_slot = out_res.play_slot;
  assign rsp.silence   = out_res.silence;
  assign rsp.status    = out_res.status;
  assign rsp.pushed_ok = out_res.pushed_ok;

endmodule

[hdl/ajb_ring_mem.sv]
// Frame number ring store: one write port, one registered read port.
module ajb_ring_mem #(
  parameter int DEPTH  = ajb_pkg::DEFAULT_RING_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = ajb_pkg::FRAME_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ajb_seq.sv]
// Playout sequencer: ring pointers, restart scan and gap check over the ring store.
module ajb_seq #(
  parameter int RING_DEPTH = ajb_pkg::DEFAULT_RING_DEPTH,
  parameter int PTR_W      = $clog2(RING_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ajb_pkg::THR_W-1:0]   start_threshold,
  ajb_req_if.sink                     req,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ajb_pkg::result_t            res,
  output logic                        mem_we,
  output logic [PTR_W-1:0]            mem_waddr,
  output logic [ajb_pkg::FRAME_W-1:0] mem_wdata,
  output logic [PTR_W-1:0]            mem_raddr,
  input  logic [ajb_pkg::FRAME_W-1:0] mem_rdata
);

  localparam int CMP_W = (PTR_W > ajb_pkg::THR_W) ? PTR_W : ajb_pkg::THR_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_W1 = (PTR_W+1)'(RING_DEPTH);

  ajb_pkg::seq_state_t state, state_next;

  logic [ajb_pkg::ACTION_W-1:0] act;
  logic [ajb_pkg::FRAME_W-1:0]  frame;
  logic [PTR_W-1:0]             head, tail, last_played;
  logic                         playing, wipe_pending;
  logic [PTR_W-1:0]             scan_ptr, cand, rd_idx;
  logic                         rd_v, have_prev;
  logic [ajb_pkg::FRAME_W-1:0]  prev, a_q;

  logic [PTR_W-1:0] h_eff, tail_inc, tail_dec, h_inc, cand_inc, head_inc;
  logic             play_eff, empty, full, start_ok, scan_done, gap;
  logic [PTR_W:0]   queued_w;
  logic [PTR_W-1:0] queued;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  // A pending wipe takes effect first on a pull.
  assign h_eff    = wipe_pending ? tail : head;
  assign play_eff = playing && !wipe_pending;
  assign tail_inc = ptr_inc(tail);
  assign tail_dec = (tail == '0) ? LAST_PTR : tail - PTR_W'(1);
  assign h_inc    = ptr_inc(h_eff);
  assign cand_inc = ptr_inc(cand);
  assign head_inc = ptr_inc(head);
  assign empty    = (h_eff == tail);
  assign full     = (tail_inc == head);
  assign queued_w = (tail >= h_eff) ? ({1'b0, tail} - {1'b0, h_eff})
                                    : ({1'b0, tail} + DEPTH_W1 - {1'b0, h_eff});
  assign queued   = queued_w[PTR_W-1:0];
  assign start_ok = CMP_W'(queued) > CMP_W'(start_threshold);
  assign scan_done = (scan_ptr == tail) && !rd_v;
  assign gap      = (a_q + ajb_pkg::FRAME_W'(1)) != mem_rdata;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ajb_pkg::S_IDLE: begin
        if (req.valid) state_next = ajb_pkg::S_EVAL;
      end
      ajb_pkg::S_EVAL: begin
        state_next = ajb_pkg::S_EMIT;
        if (act == ajb_pkg::ACT_PULL && !empty) begin
          if (!play_eff) begin
            if (start_ok) state_next = ajb_pkg::S_SCAN;
          end else if (last_played != h_eff) begin
            state_next = ajb_pkg::S_RDA;
          end
        end
      end
      ajb_pkg::S_SCAN: begin
        if (scan_done) state_next = ajb_pkg::S_EMIT;
      end
      ajb_pkg::S_RDA: state_next = ajb_pkg::S_RDB;
      ajb_pkg::S_RDB: state_next = ajb_pkg::S_CMP;
      ajb_pkg::S_CMP: state_next = ajb_pkg::S_EMIT;
      ajb_pkg::S_EMIT: begin
        if (res_ready) state_next = ajb_pkg::S_IDLE;
      end
      default: state_next = ajb_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req.ready = (state == ajb_pkg::S_IDLE);
    res_valid = (state == ajb_pkg::S_EMIT);
    mem_we    = (state == ajb_pkg::S_EVAL) && (act == ajb_pkg::ACT_PUSH) && !full;
    mem_waddr = tail;
    mem_wdata = frame;
    case (state)
      ajb_pkg::S_RDA: mem_raddr = last_played;
      ajb_pkg::S_RDB: mem_raddr = head;
      default:        mem_raddr = scan_ptr;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ajb_pkg::S_IDLE;
      head         <= '0;
      tail         <= '0;
      last_played  <= '0;
      playing      <= 1'b0;
      wipe_pending <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ajb_pkg::S_EVAL: begin
          case (act)
            ajb_pkg::ACT_PUSH: begin
              if (!full) tail <= tail_inc;
            end
            ajb_pkg::ACT_PULL: begin
              wipe_pending <= 1'b0;
              head         <= h_eff;
              if (empty || !play_eff) begin
                playing <= 1'b0;
              end else if (last_played == h_eff) begin
                head <= h_inc;
              end
            end
            ajb_pkg::ACT_WIPE: begin
              wipe_pending <= 1'b1;
              head         <= tail_dec;
            end
            default: ;
          endcase
        end
        ajb_pkg::S_SCAN: begin
          if (scan_done) begin
            playing     <= 1'b1;
            last_played <= cand;
            head        <= cand_inc;
          end
        end
        ajb_pkg::S_CMP: begin
          if (gap) begin
            playing <= 1'b0;
          end else begin
            last_played <= head;
            head        <= head_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ajb_pkg::S_IDLE: begin
        act   <= req.action;
        frame <= req.frame_number;
      end
      ajb_pkg::S_EVAL: begin
        res.play_slot <= '0;
        res.silence   <= 1'b1;
        res.status    <= ajb_pkg::ST_OTHER;
        res.pushed_ok <= (act == ajb_pkg::ACT_PUSH) && !full;
        scan_ptr      <= h_eff;
        cand          <= h_eff;
        have_prev     <= 1'b0;
        rd_v          <= 1'b0;
        if (act == ajb_pkg::ACT_PULL) begin
          if (empty) begin
            res.status <= ajb_pkg::ST_EMPTY;
          end else if (!play_eff) begin
            res.status <= ajb_pkg::ST_FILLING;
          end else if (last_played == h_eff) begin
            res.play_slot <= ajb_pkg::SLOT_W'(h_eff);
            res.silence   <= 1'b0;
            res.status    <= ajb_pkg::ST_PLAYING;
          end
        end
      end
      ajb_pkg::S_SCAN: begin
        // Stream reads from head to tail; data of a slot arrives in the next cycle.
        if (scan_ptr != tail) begin
          scan_ptr <= ptr_inc(scan_ptr);
          rd_idx   <= scan_ptr;
          rd_v     <= 1'b1;
        end else begin
          rd_v <= 1'b0;
        end
        if (rd_v) begin
          if (have_prev && (mem_rdata != prev + ajb_pkg::FRAME_W'(1))) cand <= rd_idx;
          prev      <= mem_rdata;
          have_prev <= 1'b1;
        end
        if (scan_done) begin
          res.play_slot <= ajb_pkg::SLOT_W'(cand);
          res.silence   <= 1'b0;
          res.status    <= ajb_pkg::ST_STARTED;
        end
      end
      ajb_pkg::S_RDB: begin
        a_q <= mem_rdata;
      end
      ajb_pkg::S_CMP: begin
        if (gap) begin
          res.status <= ajb_pkg::ST_GAP;
        end else begin
          res.play_slot <= ajb_pkg::SLOT_W'(head);
          res.silence   <= 1'b0;
          res.status    <= ajb_pkg::ST_PLAYING;
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/ajb_checker.sv]
// Port-level checker for the jitter buffer playout unit, bound to the top level.
`include "audio_jitter_buffer_playout_unit_defines.svh"

module ajb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic [ajb_pkg::SLOT_W-1:0]   rsp_play_slot,
  input logic                         rsp_silence,
  input logic [ajb_pkg::STATUS_W-1:0] rsp_status,
  input logic                         rsp_pushed_ok
);

  // Silent results never name a slot.
  `AJB_ASSERT_IMP(a_silence_slot, clk, rst, rsp_valid && rsp_silence, rsp_play_slot == '0)

  // A stored push reports silence with the push status.
  `AJB_ASSERT_IMP(a_push_ok, clk, rst, rsp_valid && rsp_pushed_ok, rsp_silence && (rsp_status == ajb_pkg::ST_OTHER))

  // Only playing or restart results carry audio.
  `AJB_ASSERT_IMP(a_audio_status, clk, rst, rsp_valid && !rsp_silence, (rsp_status == ajb_pkg::ST_PLAYING) || (rsp_status == ajb_pkg::ST_STARTED))

  // One request in flight: no request is taken right after another.
  `AJB_ASSERT_NXT(a_one_inflight, clk, rst, req_valid && req_ready, !req_ready)

endmodule

bind audio_jitter_buffer_playout_unit ajb_checker u_ajb_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_play_slot (rsp.play_slot),
  .rsp_silence   (rsp.silence),
  .rsp_status    (rsp.status),
  .rsp_pushed_ok (rsp.pushed_ok)
);
